// ===== rtl/tcsp_pkg.sv =====
// shared types and constants of the three-channel square tone generator
package tcsp_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } state_t;

  // address decode
  localparam logic [15:0] ADDR_MASK  = 16'hE000;
  localparam logic [15:0] ADDR_LATCH = 16'hC000;
  localparam logic [15:0] ADDR_DATA  = 16'hE000;

  // register indexes
  localparam logic [3:0] REG_PERIOD_LO_0 = 4'h0;
  localparam logic [3:0] REG_PERIOD_HI_0 = 4'h1;
  localparam logic [3:0] REG_PERIOD_LO_1 = 4'h2;
  localparam logic [3:0] REG_PERIOD_HI_1 = 4'h3;
  localparam logic [3:0] REG_PERIOD_LO_2 = 4'h4;
  localparam logic [3:0] REG_PERIOD_HI_2 = 4'h5;
  localparam logic [3:0] REG_TONE_MASK   = 4'h7;
  localparam logic [3:0] REG_VOLUME_0    = 4'h8;
  localparam logic [3:0] REG_VOLUME_1    = 4'h9;
  localparam logic [3:0] REG_VOLUME_2    = 4'hA;

  localparam int REG_CHANNELS = 3;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam int CYC_W  = 10;
  localparam int CNT_W  = 13;
  localparam int PER_W  = 12;
  localparam int PH_W   = 5;
  localparam int ACC_W  = 10;
  localparam int SMP_W  = 15;

  localparam logic signed [ACC_W-1:0] ACC_SAT_HI = 10'sd255;
  localparam logic signed [ACC_W-1:0] ACC_SAT_LO = -10'sd256;
  localparam logic signed [SMP_W-1:0] SMP_MAX    = 15'sd16383;
  localparam logic signed [SMP_W-1:0] SMP_MIN    = -15'sd16384;

endpackage

// ===== rtl/three_channel_square_psg.sv =====
// top level of the three-channel square tone generator
//
// input channel: one request per handshake. command 0 is a bus write that
// latches a register index (address top bits 110) or writes the selected
// register (top bits 111); it is absorbed in the accept cycle, no result.
// command 1 advances every enabled channel by elapsed_cycles and yields one
// sample on the output channel.
// a sample request visits each channel in turn: one load when the counter does not
// run out, or, when it does, one load, a shared one-bit-per-cycle restoring
// divider that finds how many periods passed, and one finish; then the sum is
// handed to the output register.
// in_ready is high only while the sequencer is idle, so a new sample request is
// not taken until the sequencer is done with the last one; bus writes are taken
// one per cycle while the sequencer is idle.
// the sample sits in an output register; bus writes are still taken while
// it waits. a stalled receiver holds the next sample in the sequencer until
// the register frees up.
// reset (rst_n low, synchronous) clears the control state and the tone registers,
// phases to zero and down-counters to one; datapath and output sample registers are not reset.
module three_channel_square_psg #(
  parameter int CHANNEL_COUNT = 3
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_command,
  input  logic [15:0]                     in_bus_address,
  input  logic [7:0]                      in_write_value,
  input  logic [tcsp_pkg::CYC_W-1:0]      in_elapsed_cycles,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [tcsp_pkg::SMP_W-1:0] out_sample
);

  localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNEL_COUNT - 1);
  localparam int CYC_W = tcsp_pkg::CYC_W;
  localparam int CNT_W = tcsp_pkg::CNT_W;
  localparam int PER_W = tcsp_pkg::PER_W;
  localparam int PH_W  = tcsp_pkg::PH_W;
  localparam int ACC_W = tcsp_pkg::ACC_W;
  localparam int SMP_W = tcsp_pkg::SMP_W;

  tcsp_pkg::state_t state_r, state_nxt;

  logic [3:0]             idx_r, idx_nxt;
  logic [2:0]             mask_r, mask_nxt;
  logic [PER_W-1:0]       period_r [CHANNEL_COUNT];
  logic [PER_W-1:0]       period_nxt [CHANNEL_COUNT];
  logic [3:0]             vol_r [CHANNEL_COUNT];
  logic [3:0]             vol_nxt [CHANNEL_COUNT];
  logic [PH_W-1:0]        phase_r [CHANNEL_COUNT];
  logic [PH_W-1:0]        phase_nxt [CHANNEL_COUNT];
  logic [CNT_W-1:0]       count_r [CHANNEL_COUNT];
  logic [CNT_W-1:0]       count_nxt [CHANNEL_COUNT];

  logic [CH_W-1:0]        ch_r, ch_nxt;
  logic [CYC_W-1:0]       cyc_r, cyc_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [CYC_W-1:0]       dvd_r, dvd_nxt;
  logic [CYC_W-1:0]       rem_r, rem_nxt;
  logic [PH_W-1:0]        quo_r, quo_nxt;
  logic [3:0]             bit_r, bit_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic signed [SMP_W-1:0] out_sample_r, out_sample_nxt;

  logic                   in_acc;
  logic                   out_free;
  logic                   ch_off;
  logic                   ch_last;
  logic [CNT_W:0]         diff;
  logic [CNT_W:0]         diff_neg;
  logic                   wrap;
  logic [CNT_W-1:0]       step;
  logic [CYC_W:0]         rem_sh;
  logic                   rem_ge;
  logic [PH_W-1:0]        phase_fin;
  logic [PH_W-1:0]        phase_use;
  logic [5:0]             vol3;
  logic signed [ACC_W-1:0] contrib;
  logic signed [ACC_W-1:0] acc_sum;

  // shared datapath terms
  always_comb begin
    in_acc   = in_valid && in_ready;
    out_free = !out_valid_r || out_ready;
    ch_last  = (ch_r == CH_LAST);
    ch_off   = (int'(ch_r) < tcsp_pkg::REG_CHANNELS) && mask_r[ch_r];
    step     = CNT_W'(period_r[ch_r]) + CNT_W'(1);
    diff     = {1'b0, count_r[ch_r]} - (CNT_W+1)'(cyc_r);
    diff_neg = (CNT_W+1)'(0) - diff;
    wrap     = diff[CNT_W] || (diff == '0);
    rem_sh   = {rem_r, dvd_r[CYC_W-1]};
    rem_ge   = (CNT_W'(rem_sh) >= step);
    phase_fin = phase_r[ch_r] + quo_r + PH_W'(1);
    phase_use = (state_r == tcsp_pkg::ST_FIN) ? phase_fin : phase_r[ch_r];
    vol3     = {1'b0, vol_r[ch_r], 1'b0} + {2'b00, vol_r[ch_r]};
    contrib  = phase_use[PH_W-1] ? ACC_W'(signed'({1'b0, vol3}))
                                 : -ACC_W'(signed'({1'b0, vol3}));
    acc_sum  = acc_r + contrib;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tcsp_pkg::ST_IDLE: begin
        if (in_acc && in_command == tcsp_pkg::CMD_SAMPLE) state_nxt = tcsp_pkg::ST_LOAD;
      end
      tcsp_pkg::ST_LOAD: begin
        if (!ch_off && wrap) state_nxt = tcsp_pkg::ST_DIV;
        else if (ch_last) state_nxt = tcsp_pkg::ST_DONE;
      end
      tcsp_pkg::ST_DIV: begin
        if (bit_r == '0) state_nxt = tcsp_pkg::ST_FIN;
      end
      tcsp_pkg::ST_FIN: begin
        state_nxt = ch_last ? tcsp_pkg::ST_DONE : tcsp_pkg::ST_LOAD;
      end
      tcsp_pkg::ST_DONE: begin
        if (out_free) state_nxt = tcsp_pkg::ST_IDLE;
      end
      default: state_nxt = tcsp_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready   = (state_r == tcsp_pkg::ST_IDLE);
    out_valid  = out_valid_r;
    out_sample = out_sample_r;
  end

  // register file and sequencer datapath
  always_comb begin
    idx_nxt        = idx_r;
    mask_nxt       = mask_r;
    period_nxt     = period_r;
    vol_nxt        = vol_r;
    phase_nxt      = phase_r;
    count_nxt      = count_r;
    ch_nxt         = ch_r;
    cyc_nxt        = cyc_r;
    acc_nxt        = acc_r;
    dvd_nxt        = dvd_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    bit_nxt        = bit_r;
    out_valid_nxt  = out_valid_r;
    out_sample_nxt = out_sample_r;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      tcsp_pkg::ST_IDLE: begin
        if (in_acc && in_command == tcsp_pkg::CMD_WRITE) begin
          if ((in_bus_address & tcsp_pkg::ADDR_MASK) == tcsp_pkg::ADDR_LATCH) begin
            idx_nxt = in_write_value[3:0];
          end else if ((in_bus_address & tcsp_pkg::ADDR_MASK) == tcsp_pkg::ADDR_DATA) begin
            case (idx_r) inside
              tcsp_pkg::REG_PERIOD_LO_0, tcsp_pkg::REG_PERIOD_LO_1,
              tcsp_pkg::REG_PERIOD_LO_2: begin
                for (int c = 0; c < CHANNEL_COUNT; c++) begin
                  if (c == int'(idx_r[2:1])) period_nxt[c][7:0] = in_write_value;
                end
              end
              tcsp_pkg::REG_PERIOD_HI_0, tcsp_pkg::REG_PERIOD_HI_1,
              tcsp_pkg::REG_PERIOD_HI_2: begin
                for (int c = 0; c < CHANNEL_COUNT; c++) begin
                  if (c == int'(idx_r[2:1])) period_nxt[c][11:8] = in_write_value[3:0];
                end
              end
              tcsp_pkg::REG_TONE_MASK: begin
                mask_nxt = in_write_value[2:0];
              end
              [tcsp_pkg::REG_VOLUME_0 : tcsp_pkg::REG_VOLUME_2]: begin
                for (int c = 0; c < CHANNEL_COUNT; c++) begin
                  if (c == int'(idx_r[1:0])) vol_nxt[c] = in_write_value[3:0];
                end
              end
              default: ;
            endcase
          end
        end else if (in_acc) begin
          cyc_nxt = in_elapsed_cycles;
          ch_nxt  = '0;
          acc_nxt = '0;
        end
      end
      tcsp_pkg::ST_LOAD: begin
        if (ch_off) begin
          ch_nxt = ch_r + CH_W'(1);
        end else if (wrap) begin
          dvd_nxt = diff_neg[CYC_W-1:0];
          rem_nxt = '0;
          quo_nxt = '0;
          bit_nxt = 4'(CYC_W - 1);
        end else begin
          count_nxt[ch_r] = diff[CNT_W-1:0];
          acc_nxt         = acc_sum;
          ch_nxt          = ch_r + CH_W'(1);
        end
      end
      tcsp_pkg::ST_DIV: begin
        rem_nxt = rem_ge ? CYC_W'(CNT_W'(rem_sh) - step) : rem_sh[CYC_W-1:0];
        quo_nxt = {quo_r[PH_W-2:0], rem_ge};
        dvd_nxt = {dvd_r[CYC_W-2:0], 1'b0};
        bit_nxt = bit_r - 4'd1;
      end
      tcsp_pkg::ST_FIN: begin
        count_nxt[ch_r] = step - CNT_W'(rem_r);
        phase_nxt[ch_r] = phase_fin;
        acc_nxt         = acc_sum;
        ch_nxt          = ch_r + CH_W'(1);
      end
      tcsp_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (acc_r > tcsp_pkg::ACC_SAT_HI) out_sample_nxt = tcsp_pkg::SMP_MAX;
          else if (acc_r < tcsp_pkg::ACC_SAT_LO) out_sample_nxt = tcsp_pkg::SMP_MIN;
          else out_sample_nxt = {acc_r[8:0], 6'b000000};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcsp_pkg::ST_IDLE;
      idx_r       <= '0;
      mask_r      <= '0;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
        period_r[c] <= '0;
        vol_r[c]    <= '0;
        phase_r[c]  <= '0;
        count_r[c]  <= CNT_W'(1);
      end
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      mask_r      <= mask_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
      period_r    <= period_nxt;
      vol_r       <= vol_nxt;
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cyc_r        <= cyc_nxt;
    acc_r        <= acc_nxt;
    dvd_r        <= dvd_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    bit_r        <= bit_nxt;
    out_sample_r <= out_sample_nxt;
  end

`ifndef SYNTH
  a_rem_below_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tcsp_pkg::ST_DIV |-> CNT_W'(rem_r) < step)
    else $error("divider remainder not below step");

  a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_command == tcsp_pkg::CMD_SAMPLE |=> state_r == tcsp_pkg::ST_LOAD && ch_r == '0)
    else $error("sample request did not start the sequencer");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == tcsp_pkg::ST_DONE)
    else $error("sample presented without finishing a request");

  a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tcsp_pkg::ST_LOAD || state_r == tcsp_pkg::ST_FIN |-> ch_r <= CH_LAST)
    else $error("channel index out of range");
`endif

endmodule

// ===== tb/sv/three_channel_square_psg_test.sv =====
// self-checking testbench of the three-channel square tone generator
`timescale 1ns / 100ps

module three_channel_square_psg_test;

  localparam int STALL_MAX = 14;
  localparam int QUIET_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_ITEMS = 1625;
  localparam int DIR_ROWS = 25;
  localparam logic [3:0] REG_NOISE = 4'h6;

  typedef logic signed [tcsp_pkg::SMP_W-1:0] sample_t;

  typedef struct packed {
    logic                       cmd;
    logic [15:0]                addr;
    logic [7:0]                 val;
    logic [tcsp_pkg::CYC_W-1:0] cyc;
    logic                       typed;
    sample_t                    want;
  } tone_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_command = tcsp_pkg::CMD_WRITE;
  logic [15:0] in_bus_address = '0;
  logic [7:0] in_write_value = '0;
  logic [tcsp_pkg::CYC_W-1:0] in_elapsed_cycles = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sample_t out_sample;

  three_channel_square_psg dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_bus_address    (in_bus_address),
    .in_write_value    (in_write_value),
    .in_elapsed_cycles (in_elapsed_cycles),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sample        (out_sample)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // tone generator shadow state
  logic [3:0]                 sel_index;
  logic [tcsp_pkg::PER_W-1:0] tone_period [tcsp_pkg::REG_CHANNELS];
  logic [3:0]                 tone_level [tcsp_pkg::REG_CHANNELS];
  logic                       env_mode [tcsp_pkg::REG_CHANNELS];
  logic [2:0]                 mute_mask;
  logic [tcsp_pkg::PH_W-1:0]  square_phase [tcsp_pkg::REG_CHANNELS];
  logic [13:0]                down_count [tcsp_pkg::REG_CHANNELS];

  sample_t pending_samples [$];
  int mismatches = 0;
  int quiet_cycles = 0;
  bit sender_relaxed = 1'b1;
  bit receiver_relaxed = 1'b1;

  localparam logic [3:0] MAPPED_REGS [10] = '{
    tcsp_pkg::REG_PERIOD_LO_0, tcsp_pkg::REG_PERIOD_HI_0,
    tcsp_pkg::REG_PERIOD_LO_1, tcsp_pkg::REG_PERIOD_HI_1,
    tcsp_pkg::REG_PERIOD_LO_2, tcsp_pkg::REG_PERIOD_HI_2,
    tcsp_pkg::REG_TONE_MASK, tcsp_pkg::REG_VOLUME_0,
    tcsp_pkg::REG_VOLUME_1, tcsp_pkg::REG_VOLUME_2
  };

  tone_row_t directed_rows [DIR_ROWS] = '{
    '{tcsp_pkg::CMD_SAMPLE, 16'h0000, 8'h00, 10'd0, 1'b1, 15'sd0},
    '{tcsp_pkg::CMD_SAMPLE, 16'hFFFF, 8'hFF, 10'd1023, 1'b1, 15'sd0},
    '{tcsp_pkg::CMD_WRITE, tcsp_pkg::ADDR_LATCH, {4'h0, tcsp_pkg::REG_VOLUME_0},
      10'd1023, 1'b0, 15'sd0},
    '{tcsp_pkg::CMD_WRITE, tcsp_pkg::ADDR_DATA | 16'h1FFF, 8'hFF, 10'd0, 1'b0, 15'sd0},
    '{tcsp_pkg::CMD_WRITE, tcsp_pkg::ADDR_LATCH | 16'h1FFF, {4'hF, tcsp_pkg::REG_VOLUME_1},
      10'd0, 1'b0, 15'sd0},
    '{tcsp_pkg::CMD_WRITE, tcsp_pkg::ADDR_DATA, 8'h1F, 10'd0, 1'b0, 15'sd0},
    '{tcsp_pkg::CMD_WRITE, tcsp_pkg::ADDR_LATCH | 16'h0123, {4'h0, tcsp_pkg::REG_VOLUME_2},
      10'd0, 1'b0, 15'sd0},
    '{tcsp_pkg::CMD_WRITE, tcsp_pkg::ADDR_DATA | 16'h1000, 8'h0F, 10'd0, 1'b0, 15'sd0},
    '{tcsp_pkg::CMD_SAMPLE, 16'h1234, 8'h5A, 10'd0, 1'b1, 15'sd8640},
    '{tcsp_pkg::CMD_SAMPLE, 16'hC000, 8'h07, 10'd16, 1'b1, -15'sd8640},
    '{tcsp_pkg::CMD_WRITE, tcsp_pkg::ADDR_LATCH, {4'h0, tcsp_pkg::REG_TONE_MASK},
      10'd0, 1'b0, 15'sd0},
    '{tcsp_pkg::CMD_WRITE, tcsp_pkg::ADDR_DATA, 8'h07, 10'd0, 1'b0, 15'sd0},
    '{tcsp_pkg::CMD_SAMPLE, 16'hE000, 8'h00, 10'd500, 1'b1, 15'sd0},
    '{tcsp_pkg::CMD_WRITE, tcsp_pkg::ADDR_DATA, 8'hFD, 10'd0, 1'b0, 15'sd0},
    '{tcsp_pkg::CMD_SAMPLE, 16'h0000, 8'h00, 10'd1023, 1'b0, 15'sd0},
    '{tcsp_pkg::CMD_WRITE, tcsp_pkg::ADDR_LATCH, {4'h0, tcsp_pkg::REG_PERIOD_LO_0},
      10'd0, 1'b0, 15'sd0},
    '{tcsp_pkg::CMD_WRITE, tcsp_pkg::ADDR_DATA, 8'hFF, 10'd0, 1'b0, 15'sd0},
    '{tcsp_pkg::CMD_WRITE, tcsp_pkg::ADDR_LATCH, {4'h0, tcsp_pkg::REG_PERIOD_HI_0},
      10'd0, 1'b0, 15'sd0},
    '{tcsp_pkg::CMD_WRITE, tcsp_pkg::ADDR_DATA, 8'hFF, 10'd0, 1'b0, 15'sd0},
    '{tcsp_pkg::CMD_WRITE, tcsp_pkg::ADDR_LATCH, {4'h0, REG_NOISE}, 10'd0, 1'b0, 15'sd0},
    '{tcsp_pkg::CMD_WRITE, tcsp_pkg::ADDR_DATA, 8'hAA, 10'd0, 1'b0, 15'sd0},
    '{tcsp_pkg::CMD_WRITE, 16'hBFFF, {4'h0, tcsp_pkg::REG_VOLUME_0}, 10'd0, 1'b0, 15'sd0},
    '{tcsp_pkg::CMD_WRITE, tcsp_pkg::ADDR_LATCH, {4'h0, tcsp_pkg::REG_TONE_MASK},
      10'd0, 1'b0, 15'sd0},
    '{tcsp_pkg::CMD_WRITE, 16'h7FFF, 8'h07, 10'd0, 1'b0, 15'sd0},
    '{tcsp_pkg::CMD_SAMPLE, 16'h0000, 8'h00, 10'd1023, 1'b0, 15'sd0}
  };

  task automatic reset_shadow();
    sel_index = '0;
    mute_mask = '0;
    for (int ch = 0; ch < tcsp_pkg::REG_CHANNELS; ch++) begin
      tone_period[ch] = '0;
      tone_level[ch] = '0;
      env_mode[ch] = 1'b0;
      square_phase[ch] = '0;
      down_count[ch] = 14'd1;
    end
  endtask

  task automatic apply_bus_write(input logic [15:0] addr, input logic [7:0] val);
    if ((addr & tcsp_pkg::ADDR_MASK) == tcsp_pkg::ADDR_LATCH) begin
      sel_index = val[3:0];
    end else if ((addr & tcsp_pkg::ADDR_MASK) == tcsp_pkg::ADDR_DATA) begin
      case (sel_index)
        tcsp_pkg::REG_PERIOD_LO_0, tcsp_pkg::REG_PERIOD_LO_1,
        tcsp_pkg::REG_PERIOD_LO_2: begin
          tone_period[sel_index >> 1][7:0] = val;
        end
        tcsp_pkg::REG_PERIOD_HI_0, tcsp_pkg::REG_PERIOD_HI_1,
        tcsp_pkg::REG_PERIOD_HI_2: begin
          tone_period[sel_index >> 1][11:8] = val[3:0];
        end
        tcsp_pkg::REG_TONE_MASK: begin
          mute_mask = val[2:0];
        end
        tcsp_pkg::REG_VOLUME_0, tcsp_pkg::REG_VOLUME_1, tcsp_pkg::REG_VOLUME_2: begin
          tone_level[sel_index - tcsp_pkg::REG_VOLUME_0] = val[3:0];
          env_mode[sel_index - tcsp_pkg::REG_VOLUME_0] = val[4];
        end
        default: begin
        end
      endcase
    end
  endtask

  function automatic sample_t mix_channels(input logic [tcsp_pkg::CYC_W-1:0] cyc);
    int acc;
    int left;
    int stride;
    int wraps;
    acc = 0;
    for (int ch = 0; ch < tcsp_pkg::REG_CHANNELS; ch++) begin
      if (!mute_mask[ch]) begin
        left = int'(down_count[ch]) - int'(cyc);
        if (left <= 0) begin
          stride = int'(tone_period[ch]) + 1;
          wraps = (-left) / stride + 1;
          left += wraps * stride;
          square_phase[ch] = square_phase[ch] + wraps[tcsp_pkg::PH_W-1:0];
        end
        down_count[ch] = left[13:0];
        if (square_phase[ch][tcsp_pkg::PH_W-1]) acc += 3 * int'(tone_level[ch]);
        else acc -= 3 * int'(tone_level[ch]);
      end
    end
    acc *= 64;
    if (acc > 16383) acc = 16383;
    if (acc < -16384) acc = -16384;
    return acc[tcsp_pkg::SMP_W-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t: mismatch: %s", $realtime, what);
  endtask

  task automatic send_request(input logic cmd, input logic [15:0] addr,
                              input logic [7:0] val,
                              input logic [tcsp_pkg::CYC_W-1:0] cyc,
                              input logic typed, input sample_t want);
    int gap;
    sample_t got;
    gap = sender_relaxed ? $urandom_range(0, STALL_MAX) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_bus_address <= addr;
    in_write_value <= val;
    in_elapsed_cycles <= cyc;
    do @(posedge clk); while (!in_ready);
    if (cmd == tcsp_pkg::CMD_WRITE) begin
      apply_bus_write(addr, val);
    end else begin
      got = mix_channels(cyc);
      pending_samples.push_back(typed ? want : got);
    end
  endtask

  task automatic send_random_item(inout int sent);
    int pick;
    logic [3:0] idx;
    logic [7:0] val;
    logic [tcsp_pkg::CYC_W-1:0] cyc;
    pick = $urandom_range(0, 99);
    cyc = ($urandom_range(0, 3) == 0) ? tcsp_pkg::CYC_W'($urandom_range(0, 1023))
                                      : tcsp_pkg::CYC_W'($urandom_range(0, 40));
    if (pick < 42) begin
      send_request(tcsp_pkg::CMD_SAMPLE, 16'($urandom), 8'($urandom), cyc, 1'b0, '0);
      sent++;
    end else if (pick < 90) begin
      idx = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                        : MAPPED_REGS[$urandom_range(0, 9)];
      val = 8'($urandom);
      if ((idx == tcsp_pkg::REG_PERIOD_HI_0 || idx == tcsp_pkg::REG_PERIOD_HI_1 ||
           idx == tcsp_pkg::REG_PERIOD_HI_2 || idx == tcsp_pkg::REG_TONE_MASK) &&
          $urandom_range(0, 2) != 0)
        val[3:0] = '0;
      send_request(tcsp_pkg::CMD_WRITE,
                   tcsp_pkg::ADDR_LATCH | 16'($urandom_range(0, 16'h1FFF)),
                   {4'($urandom), idx}, cyc, 1'b0, '0);
      send_request(tcsp_pkg::CMD_WRITE,
                   tcsp_pkg::ADDR_DATA | 16'($urandom_range(0, 16'h1FFF)),
                   val, cyc, 1'b0, '0);
      sent += 2;
    end else begin
      send_request(tcsp_pkg::CMD_WRITE, 16'($urandom), 8'($urandom), cyc, 1'b0, '0);
      sent++;
    end
  endtask

  initial begin
    int sent;
    reset_shadow();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_request(directed_rows[i].cmd, directed_rows[i].addr, directed_rows[i].val,
                   directed_rows[i].cyc, directed_rows[i].typed, directed_rows[i].want);
    end
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 50 < 2) sender_relaxed = ($urandom_range(0, 3) != 0);
      // let the output side drain completely now and then
      if (sent % 400 < 2 && sent > 0) begin
        in_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      send_random_item(sent);
    end
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    int stall;
    int taken;
    sample_t want;
    taken = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken % 30 == 0) receiver_relaxed = ($urandom_range(0, 3) != 0);
      stall = receiver_relaxed ? $urandom_range(0, STALL_MAX) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
      if (pending_samples.size() == 0) begin
        report_mismatch($sformatf("sample %0d with no request outstanding", out_sample));
      end else begin
        want = pending_samples.pop_front();
        if (out_sample !== want)
          report_mismatch($sformatf("sample %0d, expected %0d", out_sample, want));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $realtime, QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
